// ===== rtl/core/wsq_pkg.sv =====
package wsq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TRY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic set_head;
        logic set_tail;
    } qtab_cmd_t;

endpackage

// ===== rtl/core/per_cpu_work_stealing_queues.sv =====
// push: reads the link word (S_PRD), writes it (S_PWR), relinks the old tail in S_FIX when the queue was not empty
// try-work on own queue: S_TCHK, S_POP_HEAD, S_FIX when entries remain; a steal goes S_SCAN, S_TRD, S_POP_TAIL
// one item at a time; S_RESP loads the result once the output is free, and in_ready rises with out_valid
// the registered-read link memory read-modify-write and the one-cpu-per-cycle scan set this
// after reset the link memory is cleared entry by entry over all NUM_HANDLES entries with in_ready low
module per_cpu_work_stealing_queues #(
    parameter int NUM_CPUS    = 8,
    parameter int NUM_HANDLES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [2:0] cpu,
    input  logic [7:0] work_id,
    input  logic       steal_enable,
    input  logic [2:0] victim_seed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] found_id,
    output logic [2:0] source_cpu,
    output logic       stolen
);

    import wsq_pkg::*;

    localparam int QW = $clog2(NUM_CPUS);
    localparam int HW = $clog2(NUM_HANDLES);
    localparam int LW = HW + 1;
    localparam int DW = 2 * LW + 1;
    localparam logic [LW-1:0] NIL    = LW'(NUM_HANDLES);
    localparam logic [QW-1:0] LAST_Q = QW'(NUM_CPUS - 1);
    localparam logic [HW-1:0] LAST_H = HW'(NUM_HANDLES - 1);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_PRD      = 11'b000_0000_0100,
        S_PWR      = 11'b000_0000_1000,
        S_TCHK     = 11'b000_0001_0000,
        S_SCAN     = 11'b000_0010_0000,
        S_TRD      = 11'b000_0100_0000,
        S_POP_HEAD = 11'b000_1000_0000,
        S_POP_TAIL = 11'b001_0000_0000,
        S_FIX      = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    // input reduction tables
    logic [QW-1:0] cpu_tbl [8];
    logic [HW-1:0] wid_tbl [256];

    for (genvar g = 0; g < 8; g++)
    begin : g_cpu_tbl
        assign cpu_tbl[g] = QW'(g % NUM_CPUS);
    end

    for (genvar g = 0; g < 256; g++)
    begin : g_wid_tbl
        assign wid_tbl[g] = HW'(g % NUM_HANDLES);
    end

    state_t        state_reg, state_next;
    logic [HW-1:0] clr_reg, clr_next;
    logic          op_reg, op_next;
    logic [QW-1:0] cpu_reg, cpu_next;
    logic [QW-1:0] q_reg, q_next;
    logic [QW-1:0] j_reg, j_next;
    logic [QW-1:0] cnt_reg, cnt_next;
    logic [HW-1:0] wid_reg, wid_next;
    logic          steal_reg, steal_next;
    status_t       status_reg, status_next;
    logic [HW-1:0] found_reg, found_next;
    logic          stolen_reg, stolen_next;
    logic          fix_next_reg, fix_next_next;
    logic [LW-1:0] fix_val_reg, fix_val_next;
    logic [HW-1:0] fix_addr_reg, fix_addr_next;

    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [7:0]    out_found_reg, out_found_next;
    logic [2:0]    out_src_reg, out_src_next;
    logic          out_stolen_reg, out_stolen_next;

    logic          ram_we;
    logic [HW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [HW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    qtab_cmd_t     qcmd;
    logic [LW-1:0] head_wr, tail_wr;
    logic [LW-1:0] head_out, tail_out;
    logic [NUM_CPUS-1:0] empty_vec;

    logic          rd_queued;
    logic [LW-1:0] rd_next, rd_prev;
    logic [LW-1:0] wid_ext;
    logic [QW-1:0] j_wrap;
    logic          taken;
    logic [HW+7:0] found_wide;
    logic [QW+2:0] src_wide;

    wsq_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_HANDLES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wsq_qtab #(
        .NUM_CPUS    (NUM_CPUS),
        .NUM_HANDLES (NUM_HANDLES)
    ) u_qtab (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (qcmd),
        .idx      (q_reg),
        .head_in  (head_wr),
        .tail_in  (tail_wr),
        .head_out (head_out),
        .tail_out (tail_out),
        .empty    (empty_vec)
    );

    // link word: queued, next, prev
    assign rd_queued = ram_rdata[DW-1];
    assign rd_next   = ram_rdata[2*LW-1:LW];
    assign rd_prev   = ram_rdata[LW-1:0];
    assign wid_ext   = {1'b0, wid_reg};
    assign j_wrap    = (j_reg == LAST_Q) ? '0 : j_reg + QW'(1);
    assign taken     = (op_reg == OP_TRY) && (status_reg == ST_OK);
    assign found_wide = {8'd0, found_reg};
    assign src_wide   = {3'd0, q_reg};

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        cpu_next        = cpu_reg;
        q_next          = q_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        wid_next        = wid_reg;
        steal_next      = steal_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        stolen_next     = stolen_reg;
        fix_next_next   = fix_next_reg;
        fix_val_next    = fix_val_reg;
        fix_addr_next   = fix_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_src_next    = out_src_reg;
        out_stolen_next = out_stolen_reg;
        ram_we          = 1'b0;
        ram_waddr       = wid_reg;
        ram_wdata       = '0;
        ram_raddr       = wid_reg;
        qcmd            = '0;
        head_wr         = head_out;
        tail_wr         = tail_out;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + HW'(1);
                if (clr_reg == LAST_H)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    cpu_next    = cpu_tbl[cpu];
                    q_next      = cpu_tbl[cpu];
                    j_next      = cpu_tbl[victim_seed];
                    wid_next    = wid_tbl[work_id];
                    steal_next  = steal_enable;
                    cnt_next    = '0;
                    found_next  = '0;
                    stolen_next = 1'b0;
                    state_next  = (opcode == OP_PUSH) ? S_PRD : S_TCHK;
                end
            end
            S_PRD:
            begin
                ram_raddr  = wid_reg;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                if (rd_queued)
                begin
                    status_next = ST_DUP;
                    state_next  = S_RESP;
                end
                else
                begin
                    status_next   = ST_OK;
                    ram_we        = 1'b1;
                    ram_waddr     = wid_reg;
                    ram_wdata     = {1'b1, NIL, tail_out};
                    qcmd.set_tail = 1'b1;
                    tail_wr       = wid_ext;
                    if (empty_vec[q_reg])
                    begin
                        qcmd.set_head = 1'b1;
                        head_wr       = wid_ext;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        // old tail gets next = pushed handle
                        ram_raddr     = tail_out[HW-1:0];
                        fix_addr_next = tail_out[HW-1:0];
                        fix_next_next = 1'b1;
                        fix_val_next  = wid_ext;
                        state_next    = S_FIX;
                    end
                end
            end
            S_TCHK:
            begin
                if (!empty_vec[q_reg])
                begin
                    ram_raddr  = head_out[HW-1:0];
                    state_next = S_POP_HEAD;
                end
                else if (steal_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_RESP;
                end
            end
            S_SCAN:
            begin
                if ((j_reg != cpu_reg) && !empty_vec[j_reg])
                begin
                    q_next      = j_reg;
                    stolen_next = 1'b1;
                    state_next  = S_TRD;
                end
                else if (cnt_reg == LAST_Q)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_RESP;
                end
                else
                begin
                    j_next   = j_wrap;
                    cnt_next = cnt_reg + QW'(1);
                end
            end
            S_TRD:
            begin
                ram_raddr  = tail_out[HW-1:0];
                state_next = S_POP_TAIL;
            end
            S_POP_HEAD:
            begin
                status_next   = ST_OK;
                found_next    = head_out[HW-1:0];
                ram_we        = 1'b1;
                ram_waddr     = head_out[HW-1:0];
                ram_wdata     = {1'b0, NIL, rd_prev};
                qcmd.set_head = 1'b1;
                head_wr       = rd_next;
                if (rd_next == NIL)
                begin
                    qcmd.set_tail = 1'b1;
                    tail_wr       = NIL;
                    state_next    = S_RESP;
                end
                else
                begin
                    // new head gets prev = null
                    ram_raddr     = rd_next[HW-1:0];
                    fix_addr_next = rd_next[HW-1:0];
                    fix_next_next = 1'b0;
                    fix_val_next  = NIL;
                    state_next    = S_FIX;
                end
            end
            S_POP_TAIL:
            begin
                status_next   = ST_OK;
                found_next    = tail_out[HW-1:0];
                ram_we        = 1'b1;
                ram_waddr     = tail_out[HW-1:0];
                ram_wdata     = {1'b0, rd_next, NIL};
                qcmd.set_tail = 1'b1;
                tail_wr       = rd_prev;
                if (rd_prev == NIL)
                begin
                    qcmd.set_head = 1'b1;
                    head_wr       = NIL;
                    state_next    = S_RESP;
                end
                else
                begin
                    // new tail gets next = null
                    ram_raddr     = rd_prev[HW-1:0];
                    fix_addr_next = rd_prev[HW-1:0];
                    fix_next_next = 1'b1;
                    fix_val_next  = NIL;
                    state_next    = S_FIX;
                end
            end
            S_FIX:
            begin
                ram_we    = 1'b1;
                ram_waddr = fix_addr_reg;
                ram_wdata = fix_next_reg ? {rd_queued, fix_val_reg, rd_prev}
                                         : {rd_queued, rd_next, fix_val_reg};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = taken ? found_wide[7:0] : 8'd0;
                    out_src_next    = taken ? src_wide[2:0] : 3'd0;
                    out_stolen_next = taken && stolen_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            q_reg         <= q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cpu_reg        <= cpu_next;
        j_reg          <= j_next;
        cnt_reg        <= cnt_next;
        wid_reg        <= wid_next;
        steal_reg      <= steal_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        stolen_reg     <= stolen_next;
        fix_next_reg   <= fix_next_next;
        fix_val_reg    <= fix_val_next;
        fix_addr_reg   <= fix_addr_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_src_reg    <= out_src_next;
        out_stolen_reg <= out_stolen_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_id   = out_found_reg;
    assign source_cpu = out_src_reg;
    assign stolen     = out_stolen_reg;

`ifndef NO_ASSERTIONS
    a_head_tail_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_out == NIL) == (tail_out == NIL))
        else $error("queue head and tail disagree on empty");

    a_pop_head_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_HEAD) |-> rd_queued)
        else $error("queue head not marked queued");

    a_pop_tail_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_TAIL) |-> rd_queued)
        else $error("queue tail not marked queued");

    a_push_old_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX && op_reg == OP_PUSH) |-> (rd_queued && rd_next == NIL))
        else $error("old tail not a proper tail on push");
`endif

endmodule

// ===== rtl/core/wsq_ram.sv =====
module wsq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wsq_qtab.sv =====
module wsq_qtab #(
    parameter int NUM_CPUS    = 8,
    parameter int NUM_HANDLES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsq_pkg::qtab_cmd_t            cmd,
    input  logic [$clog2(NUM_CPUS)-1:0]   idx,
    input  logic [$clog2(NUM_HANDLES):0]  head_in,
    input  logic [$clog2(NUM_HANDLES):0]  tail_in,
    output logic [$clog2(NUM_HANDLES):0]  head_out,
    output logic [$clog2(NUM_HANDLES):0]  tail_out,
    output logic [NUM_CPUS-1:0]           empty
);

    import wsq_pkg::*;

    localparam int LW = $clog2(NUM_HANDLES) + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_HANDLES);

    logic [LW-1:0] head_reg  [NUM_CPUS];
    logic [LW-1:0] tail_reg  [NUM_CPUS];
    logic [LW-1:0] head_next [NUM_CPUS];
    logic [LW-1:0] tail_next [NUM_CPUS];

    always_comb
    begin
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        if (cmd.set_head)
        begin
            head_next[idx] = head_in;
        end
        if (cmd.set_tail)
        begin
            tail_next[idx] = tail_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    assign head_out = head_reg[idx];
    assign tail_out = tail_reg[idx];

    for (genvar g = 0; g < NUM_CPUS; g++)
    begin : g_empty
        assign empty[g] = (head_reg[g] == NIL);
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import wsq_pkg::*;

    localparam int  NCPU        = 8;
    localparam int  NHANDLE     = 256;
    localparam int  RANDOM_REQS = 500;
    localparam int  CYCLE_LIMIT = 250000;
    localparam logic [8:0] NIL  = 9'd256;

    typedef struct {
        status_t    st;
        logic [7:0] id;
        logic [2:0] src;
        logic       stole;
    } grant_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_RARE
    } rx_mode_t;

    class steal_queue_predictor;
        logic [8:0] head_q[NCPU];
        logic [8:0] tail_q[NCPU];
        logic [8:0] next_h[NHANDLE];
        logic [8:0] prev_h[NHANDLE];
        bit         queued[NHANDLE];
        int         queued_total;
        int         mismatches;
        grant_t     expected_grants[$];

        function new();
            for (int i = 0; i < NCPU; i++)
            begin
                head_q[i] = NIL;
                tail_q[i] = NIL;
            end
            for (int i = 0; i < NHANDLE; i++)
            begin
                next_h[i] = 9'd0;
                prev_h[i] = 9'd0;
                queued[i] = 1'b0;
            end
            queued_total = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        function logic [7:0] pop_front_of(logic [2:0] c);
            logic [7:0] h;
            logic [8:0] n;
            h = head_q[c][7:0];
            n = next_h[h];
            head_q[c] = n;
            if (n != NIL)
                prev_h[n[7:0]] = NIL;
            else
                tail_q[c] = NIL;
            next_h[h] = NIL;
            queued[h] = 1'b0;
            queued_total--;
            return h;
        endfunction

        function logic [7:0] pop_back_of(logic [2:0] c);
            logic [7:0] t;
            logic [8:0] p;
            t = tail_q[c][7:0];
            p = prev_h[t];
            tail_q[c] = p;
            if (p != NIL)
                next_h[p[7:0]] = NIL;
            else
                head_q[c] = NIL;
            prev_h[t] = NIL;
            queued[t] = 1'b0;
            queued_total--;
            return t;
        endfunction

        function void note_request(logic op, logic [2:0] c, logic [7:0] w,
                                   logic steal, logic [2:0] seed);
            grant_t     g;
            logic [2:0] j;
            logic [8:0] t;
            g.st    = ST_EMPTY;
            g.id    = 8'd0;
            g.src   = 3'd0;
            g.stole = 1'b0;
            if (op == OP_PUSH)
            begin
                if (queued[w])
                    g.st = ST_DUP;
                else
                begin
                    t = tail_q[c];
                    prev_h[w] = t;
                    next_h[w] = NIL;
                    if (t != NIL)
                        next_h[t[7:0]] = {1'b0, w};
                    else
                        head_q[c] = {1'b0, w};
                    tail_q[c] = {1'b0, w};
                    queued[w] = 1'b1;
                    queued_total++;
                    g.st = ST_OK;
                end
            end
            else if (head_q[c] != NIL)
            begin
                g.id  = pop_front_of(c);
                g.src = c;
                g.st  = ST_OK;
            end
            else if (steal)
            begin
                for (int i = 0; i < NCPU; i++)
                begin
                    j = seed + 3'(i);
                    if (j != c && tail_q[j] != NIL && g.st == ST_EMPTY)
                    begin
                        g.id    = pop_back_of(j);
                        g.src   = j;
                        g.stole = 1'b1;
                        g.st    = ST_OK;
                    end
                end
            end
            expected_grants.push_back(g);
        endfunction

        function void check_grant(logic [1:0] st, logic [7:0] id, logic [2:0] src,
                                  logic stole);
            grant_t g;
            if (expected_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d id %0d src %0d stolen %0d",
                             st, id, src, stole);
                return;
            end
            g = expected_grants.pop_front();
            if (st !== g.st || id !== g.id || src !== g.src || stole !== g.stole)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp status %0d id %0d src %0d stolen %0d, got %0d %0d %0d %0d",
                             g.st, g.id, g.src, g.stole, st, id, src, stole);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [2:0] cpu;
    logic [7:0] work_id;
    logic       steal_enable;
    logic [2:0] victim_seed;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [7:0] found_id;
    logic [2:0] source_cpu;
    logic       stolen;

    steal_queue_predictor sched = new();
    int burst_left;
    int cycles;

    per_cpu_work_stealing_queues u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .cpu          (cpu),
        .work_id      (work_id),
        .steal_enable (steal_enable),
        .victim_seed  (victim_seed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_id     (found_id),
        .source_cpu   (source_cpu),
        .stolen       (stolen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // receiver stall patterns
    initial
    begin
        rx_mode_t mode;
        int       len;
        int       phase;
        out_ready = 1'b0;
        phase = 0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(5, 60);
            repeat (len)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    RX_ALWAYS:   out_ready <= 1'b1;
                    RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: out_ready <= (phase % 5) > 1;
                    default:     out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sched.check_grant(status, found_id, source_cpu, stolen);
    end

    task automatic send_word(logic op, logic [2:0] c, logic [7:0] w, logic steal,
                             logic [2:0] seed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        cpu          <= c;
        work_id      <= w;
        steal_enable <= steal;
        victim_seed  <= seed;
        do
            @(posedge clk);
        while (!in_ready);
        sched.note_request(op, c, w, steal, seed);
    endtask

    task automatic send_random_word();
        logic       op;
        logic [7:0] w;
        int         push_pct;
        if (sched.queued_total < 4)
            push_pct = 70;
        else if (sched.queued_total > 40)
            push_pct = 35;
        else
            push_pct = 52;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TRY;
        w  = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        send_word(op, 3'($urandom_range(0, 7)), w, ($urandom_range(0, 4) != 0),
                  3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_PUSH;
        cpu          = 3'd0;
        work_id      = 8'd0;
        steal_enable = 1'b0;
        victim_seed  = 3'd0;
        burst_left   = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // empty everywhere, with and without stealing
        send_word(OP_TRY,  3'd0, 8'd0,   1'b0, 3'd0);
        send_word(OP_TRY,  3'd7, 8'd255, 1'b1, 3'd7);
        // single-entry queue still counts as queued
        send_word(OP_PUSH, 3'd3, 8'd0,   1'b0, 3'd0);
        send_word(OP_PUSH, 3'd5, 8'd0,   1'b1, 3'd7);
        send_word(OP_PUSH, 3'd3, 8'd255, 1'b0, 3'd0);
        send_word(OP_PUSH, 3'd3, 8'd255, 1'b0, 3'd0);
        send_word(OP_PUSH, 3'd6, 8'haa,  1'b0, 3'd0);
        send_word(OP_PUSH, 3'd6, 8'h55,  1'b0, 3'd0);
        send_word(OP_TRY,  3'd3, 8'h5a,  1'b0, 3'd0);
        // stealing off: others nonempty but no work; then tries with stealing on
        send_word(OP_TRY,  3'd0, 8'd0,   1'b0, 3'd0);
        send_word(OP_TRY,  3'd0, 8'd0,   1'b1, 3'd6);
        send_word(OP_TRY,  3'd6, 8'd0,   1'b1, 3'd6);
        // scan starts on self, skips it
        send_word(OP_TRY,  3'd6, 8'd0,   1'b1, 3'd6);
        send_word(OP_PUSH, 3'd7, 8'd1,   1'b0, 3'd0);
        send_word(OP_PUSH, 3'd1, 8'd2,   1'b0, 3'd0);
        send_word(OP_TRY,  3'd7, 8'd0,   1'b1, 3'd7);
        // scan wraps past the top cpu
        send_word(OP_TRY,  3'd7, 8'd0,   1'b1, 3'd7);
        send_word(OP_PUSH, 3'd0, 8'd0,   1'b0, 3'd0);
        send_word(OP_TRY,  3'd0, 8'hff,  1'b1, 3'd3);
        send_word(OP_TRY,  3'd2, 8'd0,   1'b1, 3'd1);

        for (int n = 0; n < RANDOM_REQS; n++)
            send_random_word();

        @(negedge clk);
        in_valid <= 1'b0;
        while (sched.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sched.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
